// ===== hdl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 cipher package
// Shared constants, controller states and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int          PERM_DEPTH   = 256;
    localparam int          PERM_AW      = 8;
    localparam int          KEY_BYTES_DEF = 4;
    localparam logic [31:0] KEY_RESET    = 32'h656B_6963;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KS_RD_A,
        ST_KS_RD_B,
        ST_KS_WR_A,
        ST_KS_WR_B,
        ST_G_INC,
        ST_G_RD_I,
        ST_G_RD_J,
        ST_G_WR_I,
        ST_G_WR_J,
        ST_G_RD_K,
        ST_G_OUT
    } rc4_state_t;

    typedef enum logic [2:0] {
        ADDR_A,
        ADDR_B_NEW,
        ADDR_B,
        ADDR_I,
        ADDR_J_NEW,
        ADDR_J,
        ADDR_K
    } rc4_addr_sel_t;

    typedef enum logic [1:0] {
        WD_COUNT,
        WD_RDATA,
        WD_HOLD_X
    } rc4_wd_sel_t;

    typedef struct packed {
        logic          mem_we;
        rc4_addr_sel_t addr_sel;
        rc4_wd_sel_t   wd_sel;
        logic          sched_clr;
        logic          a_inc;
        logic          b_load;
        logic          kidx_inc;
        logic          i_inc;
        logic          j_load;
        logic          x_load;
        logic          y_load;
        logic          data_load;
        logic          out_load;
    } rc4_cmd_t;

    typedef struct packed {
        logic a_last;
        logic out_free;
    } rc4_status_t;

endpackage

// ===== hdl/rc4_stream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher top level
// XORs each data byte with one RC4 keystream byte; reruns the key schedule
// on the first byte after reset and on every start of message.
//
//   channel  direction  ports                        contents
//   s_       in         s_tvalid/s_tready/s_tdata    tdata[7:0] data_byte
//                       s_tuser                      tuser[0] start_of_message
//   m_       out        m_tvalid/m_tready/m_tdata    tdata[7:0] cipher_byte
//   cfg_     in         cfg_valid/cfg_ready/cfg_data key_bytes, byte n at [8n+7:8n]
//
// Each byte runs an index step, five accesses to the one single-port
// permutation memory (each swap read-then-write) and the output load; a new
// byte is taken only after the last one is loaded.
// A byte that triggers the key schedule first fills the table with 256
// writes, then makes 4 memory accesses for each of the 256 schedule steps.
// After reset the permutation table is unwritten; the first byte always
// schedules. aresetn is synchronous, active low.
// A result waiting in the output register stalls only the final step of the
// next byte; input is taken again as soon as that result is loaded.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top #(
    parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] cipher_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import rc4_pkg::*;

    rc4_cmd_t    cmd;
    rc4_status_t status;

    rc4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    rc4_dpath #(
        .KEY_BYTES (KEY_BYTES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== hdl/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences the table fill, the key schedule and the keystream step over
// the single-port permutation memory in the datapath.
// ----------------------------------------------------------------------------
module rc4_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    input  rc4_pkg::rc4_status_t status,
    output rc4_pkg::rc4_cmd_t   cmd
);
    import rc4_pkg::*;

    rc4_state_t state_reg, state_next;
    logic       sched_valid_reg, sched_valid_next;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sched_valid_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            sched_valid_reg <= sched_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next       = state_reg;
        sched_valid_next = sched_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser || !sched_valid_reg) begin
                        state_next = ST_INIT;
                    end else begin
                        state_next = ST_G_INC;
                    end
                end
            end
            ST_INIT: begin
                if (status.a_last) begin
                    state_next = ST_KS_RD_A;
                end
            end
            ST_KS_RD_A: state_next = ST_KS_RD_B;
            ST_KS_RD_B: state_next = ST_KS_WR_A;
            ST_KS_WR_A: state_next = ST_KS_WR_B;
            ST_KS_WR_B: begin
                if (status.a_last) begin
                    state_next       = ST_G_INC;
                    sched_valid_next = 1'b1;
                end else begin
                    state_next = ST_KS_RD_A;
                end
            end
            ST_G_INC:  state_next = ST_G_RD_I;
            ST_G_RD_I: state_next = ST_G_RD_J;
            ST_G_RD_J: state_next = ST_G_WR_I;
            ST_G_WR_I: state_next = ST_G_WR_J;
            ST_G_WR_J: state_next = ST_G_RD_K;
            ST_G_RD_K: state_next = ST_G_OUT;
            ST_G_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // ready is always high here, so valid alone marks the transaction
                s_tready      = 1'b1;
                cmd.data_load = s_tvalid;
                cmd.sched_clr = s_tvalid && (s_tuser || !sched_valid_reg);
            end
            ST_INIT: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_A;
                cmd.wd_sel   = WD_COUNT;
                cmd.a_inc    = 1'b1;
            end
            ST_KS_RD_A: begin
                cmd.addr_sel = ADDR_A;
            end
            ST_KS_RD_B: begin
                cmd.addr_sel = ADDR_B_NEW;
                cmd.x_load   = 1'b1;
                cmd.b_load   = 1'b1;
            end
            ST_KS_WR_A: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_A;
                cmd.wd_sel   = WD_RDATA;
            end
            ST_KS_WR_B: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_B;
                cmd.wd_sel   = WD_HOLD_X;
                cmd.a_inc    = 1'b1;
                cmd.kidx_inc = 1'b1;
            end
            ST_G_INC: begin
                cmd.i_inc = 1'b1;
            end
            ST_G_RD_I: begin
                cmd.addr_sel = ADDR_I;
            end
            ST_G_RD_J: begin
                cmd.addr_sel = ADDR_J_NEW;
                cmd.x_load   = 1'b1;
                cmd.j_load   = 1'b1;
            end
            ST_G_WR_I: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_I;
                cmd.wd_sel   = WD_RDATA;
                cmd.y_load   = 1'b1;
            end
            ST_G_WR_J: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_J;
                cmd.wd_sel   = WD_HOLD_X;
            end
            ST_G_RD_K: begin
                cmd.addr_sel = ADDR_K;
            end
            ST_G_OUT: begin
                // keep the keystream address so the read data holds during a stall
                cmd.addr_sel = ADDR_K;
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !cmd.mem_we)
        else $error("permutation write while idle");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while one is in progress");

    a_gen_after_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_G_INC) |-> sched_valid_reg)
        else $error("keystream step without a completed key schedule");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over one not yet taken");
`endif

endmodule

// ===== hdl/rc4_dpath.sv =====
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation memory, indices, key register and the output register.
// ----------------------------------------------------------------------------
module rc4_dpath #(
    parameter int KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rc4_pkg::rc4_cmd_t    cmd,
    output rc4_pkg::rc4_status_t status,
    input  logic [7:0]           s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);
    import rc4_pkg::*;

    localparam int KEY_LEN = (KEY_BYTES < 1) ? 1 : ((KEY_BYTES > 4) ? 4 : KEY_BYTES);
    localparam logic [1:0] KIDX_LAST = 2'(KEY_LEN - 1);

    logic [7:0]         perm_mem [PERM_DEPTH];
    logic [7:0]         rdata_reg;
    logic [PERM_AW-1:0] mem_addr;
    logic [7:0]         mem_wdata;

    logic [31:0]        key_reg, key_next;
    logic [PERM_AW-1:0] a_reg, a_next;
    logic [7:0]         b_reg, b_next;
    logic [1:0]         kidx_reg, kidx_next;
    logic [7:0]         i_reg, i_next;
    logic [7:0]         j_reg, j_next;
    logic [7:0]         x_reg, y_reg, data_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [7:0]         m_tdata_reg;

    logic [7:0]         key_byte;
    logic [7:0]         b_sum;
    logic [7:0]         j_sum;
    logic [7:0]         k_addr;

    assign key_byte = key_reg[{kidx_reg, 3'b000} +: 8];
    assign b_sum    = b_reg + rdata_reg + key_byte;
    assign j_sum    = j_reg + rdata_reg;
    assign k_addr   = x_reg + y_reg;

    always_comb begin
        case (cmd.addr_sel)
            ADDR_A:     mem_addr = a_reg;
            ADDR_B_NEW: mem_addr = b_sum;
            ADDR_B:     mem_addr = b_reg;
            ADDR_I:     mem_addr = i_reg;
            ADDR_J_NEW: mem_addr = j_sum;
            ADDR_J:     mem_addr = j_reg;
            ADDR_K:     mem_addr = k_addr;
            default:    mem_addr = a_reg;
        endcase
    end

    always_comb begin
        case (cmd.wd_sel)
            WD_COUNT:  mem_wdata = a_reg;
            WD_RDATA:  mem_wdata = rdata_reg;
            WD_HOLD_X: mem_wdata = x_reg;
            default:   mem_wdata = rdata_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            perm_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= perm_mem[mem_addr];
    end

    always_comb begin
        key_next      = cfg_valid ? cfg_data : key_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        kidx_next     = kidx_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        m_tvalid_next = m_tvalid_reg;
        if (cmd.sched_clr) begin
            a_next    = '0;
            b_next    = '0;
            kidx_next = '0;
            i_next    = '0;
            j_next    = '0;
        end else begin
            if (cmd.a_inc) begin
                a_next = a_reg + 1'b1;
            end
            if (cmd.b_load) begin
                b_next = b_sum;
            end
            if (cmd.kidx_inc) begin
                kidx_next = (kidx_reg == KIDX_LAST) ? 2'd0 : kidx_reg + 2'd1;
            end
            if (cmd.i_inc) begin
                i_next = i_reg + 8'd1;
            end
            if (cmd.j_load) begin
                j_next = j_sum;
            end
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg      <= KEY_RESET;
            a_reg        <= '0;
            b_reg        <= '0;
            kidx_reg     <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            key_reg      <= key_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            kidx_reg     <= kidx_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.x_load) begin
            x_reg <= rdata_reg;
        end
        if (cmd.y_load) begin
            y_reg <= rdata_reg;
        end
        if (cmd.data_load) begin
            data_reg <= s_tdata;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= data_reg ^ rdata_reg;
        end
    end

    assign status.a_last   = (a_reg == PERM_AW'(PERM_DEPTH - 1));
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule
